// ===== rtl/scs_pkg.sv =====
// shared types and constants for the swap candidate selector
package scs_pkg;

   // process status codes
   localparam logic [2:0] ST_EMPTY  = 3'd0;
   localparam logic [2:0] ST_SLEEP  = 3'd1;
   localparam logic [2:0] ST_WAIT   = 3'd2;
   localparam logic [2:0] ST_RUN    = 3'd3;
   localparam logic [2:0] ST_CREATE = 3'd4;
   localparam logic [2:0] ST_ZOMB   = 3'd5;
   localparam logic [2:0] ST_STOP   = 3'd6;

   // decision codes
   localparam logic [1:0] ACT_NONE     = 2'd0;
   localparam logic [1:0] ACT_IN       = 2'd1;
   localparam logic [1:0] ACT_OUT_IN   = 2'd2;
   localparam logic [1:0] ACT_WAIT     = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_NICE_SHIFT    = 2'd0;
   localparam logic [1:0] CSR_MIN_OUT_TIME  = 2'd1;
   localparam logic [1:0] CSR_MIN_CORE_TIME = 2'd2;

   // register reset values
   localparam logic [2:0]         NICE_SHIFT_RST    = 3'd3;
   localparam logic signed [12:0] MIN_OUT_TIME_RST  = 13'sd2;
   localparam logic signed [8:0]  MIN_CORE_TIME_RST = 9'sd1;

   // swap-in priority saturation bounds
   localparam logic signed [13:0] PRIO_MAX = 14'sd4095;
   localparam logic signed [13:0] PRIO_MIN = -14'sd4096;

   localparam int unsigned FIELD_ID_W = 8;

   // fields of one table entry as carried on req_tdata
   typedef struct packed {
      logic signed [5:0] nice;
      logic [6:0]        time_in_state;
      logic              interruptible;
      logic              locked;
      logic              vfork_parent;
      logic              system_proc;
      logic              loaded;
      logic [2:0]        status;
      logic [7:0]        proc_id;
   } entry_type;

   // scan state after the entry in the input register is folded in
   typedef struct packed {
      logic               valid;
      logic               last;
      logic               in_found;
      logic signed [12:0] in_priority;
      logic               out_found;
      logic [2:0]         out_status;
      logic               out_locked;
      logic               out_interruptible;
      logic signed [8:0]  out_core_time;
   } scan_view_type;

endpackage

// ===== rtl/scs_scan.sv =====
// input register and running swap-in / swap-out candidate state
module scs_scan
   import scs_pkg::*;
#(
   parameter int ID_WIDTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,
   input  logic                req_tlast,
   input  logic [2:0]          nice_shift,
   input  logic                room,
   output scan_view_type       view,
   output logic [ID_WIDTH-1:0] view_in_id,
   output logic [ID_WIDTH-1:0] view_out_id
);

   localparam int IdPadW = (ID_WIDTH > FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff;
   entry_type         s1_entry_ff;
   logic              advance;

   logic                in_found_ff, in_found_in;
   logic [ID_WIDTH-1:0] in_id_ff, in_id_in;
   logic signed [12:0]  in_priority_ff, in_priority_in;
   logic                search_closed_ff, search_closed_in;
   logic                out_found_ff, out_found_in;
   logic [ID_WIDTH-1:0] out_id_ff, out_id_in;
   logic [2:0]          out_status_ff, out_status_in;
   logic                out_locked_ff, out_locked_in;
   logic                out_interruptible_ff, out_interruptible_in;
   logic signed [8:0]   out_core_time_ff, out_core_time_in;

   logic [IdPadW-1:0]   id_pad;
   logic [ID_WIDTH-1:0] id;
   logic signed [13:0]  nice_w;
   logic signed [13:0]  prio_w;
   logic signed [12:0]  prio;
   logic                in_cand, in_take, out_take;

   // an entry waits only when it closes a scan and the result slot is full
   assign advance     = !s1_last_ff || room;
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_tready && req_tvalid) begin
            s1_last_ff <= req_tlast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_entry_ff <= entry_type'(req_tdata[$bits(entry_type)-1:0]);
      end
   end

   always_comb begin
      id_pad  = IdPadW'(s1_entry_ff.proc_id);
      id      = id_pad[ID_WIDTH-1:0];
      nice_w  = {{8{s1_entry_ff.nice[5]}}, s1_entry_ff.nice};
      prio_w  = signed'({7'b0, s1_entry_ff.time_in_state}) - (nice_w <<< nice_shift);
      if (prio_w > PRIO_MAX) begin
         prio = PRIO_MAX[12:0];
      end else if (prio_w < PRIO_MIN) begin
         prio = PRIO_MIN[12:0];
      end else begin
         prio = prio_w[12:0];
      end

      in_cand = !search_closed_ff && (s1_entry_ff.status == ST_RUN) && !s1_entry_ff.loaded;
      in_take = in_cand && (!in_found_ff || (prio > in_priority_ff) ||
                            s1_entry_ff.vfork_parent);
      out_take = !out_found_ff && s1_entry_ff.loaded && !s1_entry_ff.system_proc &&
                 (s1_entry_ff.status != ST_ZOMB);

      in_found_in      = in_found_ff || in_take;
      in_id_in         = in_take ? id : in_id_ff;
      in_priority_in   = in_take ? prio : in_priority_ff;
      search_closed_in = search_closed_ff || (in_take && s1_entry_ff.vfork_parent);

      out_found_in         = out_found_ff || out_take;
      out_id_in            = out_take ? id : out_id_ff;
      out_status_in        = out_take ? s1_entry_ff.status : out_status_ff;
      out_locked_in        = out_take ? s1_entry_ff.locked : out_locked_ff;
      out_interruptible_in = out_take ? s1_entry_ff.interruptible : out_interruptible_ff;
      out_core_time_in     = out_take ?
                             (signed'({2'b0, s1_entry_ff.time_in_state}) +
                              {{3{s1_entry_ff.nice[5]}}, s1_entry_ff.nice}) :
                             out_core_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_valid_ff && advance && s1_last_ff)) begin
         in_found_ff          <= 1'b0;
         in_id_ff             <= '0;
         in_priority_ff       <= '0;
         search_closed_ff     <= 1'b0;
         out_found_ff         <= 1'b0;
         out_id_ff            <= '0;
         out_status_ff        <= ST_EMPTY;
         out_locked_ff        <= 1'b0;
         out_interruptible_ff <= 1'b0;
         out_core_time_ff     <= '0;
      end else if (s1_valid_ff) begin
         in_found_ff          <= in_found_in;
         in_id_ff             <= in_id_in;
         in_priority_ff       <= in_priority_in;
         search_closed_ff     <= search_closed_in;
         out_found_ff         <= out_found_in;
         out_id_ff            <= out_id_in;
         out_status_ff        <= out_status_in;
         out_locked_ff        <= out_locked_in;
         out_interruptible_ff <= out_interruptible_in;
         out_core_time_ff     <= out_core_time_in;
      end
   end

   always_comb begin
      view.valid             = s1_valid_ff;
      view.last              = s1_last_ff;
      view.in_found          = in_found_in;
      view.in_priority       = in_priority_in;
      view.out_found         = out_found_in;
      view.out_status        = out_status_in;
      view.out_locked        = out_locked_in;
      view.out_interruptible = out_interruptible_in;
      view.out_core_time     = out_core_time_in;
      view_in_id             = in_id_in;
      view_out_id            = out_id_in;
   end

endmodule

// ===== rtl/scs_result.sv =====
// swap decision logic and result register
module scs_result
   import scs_pkg::*;
#(
   parameter int ID_WIDTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  scan_view_type       view,
   input  logic [ID_WIDTH-1:0] view_in_id,
   input  logic [ID_WIDTH-1:0] view_out_id,
   input  logic signed [12:0]  min_out_time,
   input  logic signed [8:0]   min_core_time,
   output logic                room,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata
);

   localparam int IdPadW = (ID_WIDTH > FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        action_ff, action_in;
   logic [7:0]        swap_in_id_ff, swap_in_id_in;
   logic [7:0]        swap_out_id_ff, swap_out_id_in;
   logic              dequeue_run_ff, dequeue_run_in;
   logic              fire, evict, busy_ok;
   logic [IdPadW-1:0] in_pad, out_pad;

   assign room = !rsp_valid_ff || rsp_tready;
   assign fire = view.valid && view.last && room;

   always_comb begin
      in_pad  = IdPadW'(view_in_id);
      out_pad = IdPadW'(view_out_id);

      busy_ok = ((view.out_status == ST_RUN) || (view.out_status == ST_SLEEP)) &&
                (view.in_priority >= min_out_time) &&
                (view.out_core_time >= min_core_time);
      evict   = !view.out_locked &&
                ((view.out_status == ST_STOP) ||
                 ((view.out_status == ST_SLEEP) && view.out_interruptible) ||
                 busy_ok);

      action_in      = ACT_NONE;
      swap_in_id_in  = '0;
      swap_out_id_in = '0;
      dequeue_run_in = 1'b0;
      if (view.in_found) begin
         if (!view.out_found) begin
            action_in     = ACT_IN;
            swap_in_id_in = in_pad[7:0];
         end else if (evict) begin
            action_in      = ACT_OUT_IN;
            swap_in_id_in  = in_pad[7:0];
            swap_out_id_in = out_pad[7:0];
            dequeue_run_in = (view.out_status == ST_RUN);
         end else begin
            action_in = ACT_WAIT;
         end
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         action_ff      <= action_in;
         swap_in_id_ff  <= swap_in_id_in;
         swap_out_id_ff <= swap_out_id_in;
         dequeue_run_ff <= dequeue_run_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, dequeue_run_ff, swap_out_id_ff, swap_in_id_ff, action_ff};

endmodule

// ===== rtl/swap_candidate_selector.sv =====
// swap candidate selector: one table entry per transfer, one decision per scan
// a scan's decision passes the input register and the result register
// throughput: one entry per cycle; a last entry waits only while a result is held
// reset: synchronous, clears scan state and handshake state, restores register defaults
module swap_candidate_selector
   import scs_pkg::*;
#(
   parameter int ID_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // proc_id[7:0], status[10:8], loaded[11], system_proc[12], vfork_parent[13],
   // locked[14], interruptible[15], time_in_state[22:16], nice[28:23], zero fill
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // action[1:0], swap_in_id[9:2], swap_out_id[17:10], dequeue_run[18], zero fill
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   logic [2:0]          nice_shift_ff;
   logic signed [12:0]  min_out_time_ff;
   logic signed [8:0]   min_core_time_ff;
   scan_view_type       view;
   logic [ID_WIDTH-1:0] view_in_id, view_out_id;
   logic                room;

   always_ff @(posedge clock) begin
      if (reset) begin
         nice_shift_ff    <= NICE_SHIFT_RST;
         min_out_time_ff  <= MIN_OUT_TIME_RST;
         min_core_time_ff <= MIN_CORE_TIME_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NICE_SHIFT:    nice_shift_ff    <= csr_wdata[2:0];
            CSR_MIN_OUT_TIME:  min_out_time_ff  <= signed'(csr_wdata);
            CSR_MIN_CORE_TIME: min_core_time_ff <= signed'(csr_wdata[8:0]);
            default: ;
         endcase
      end
   end

   scs_scan #(
      .ID_WIDTH(ID_WIDTH)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .nice_shift  (nice_shift_ff),
      .room        (room),
      .view        (view),
      .view_in_id  (view_in_id),
      .view_out_id (view_out_id)
   );

   scs_result #(
      .ID_WIDTH(ID_WIDTH)
   ) u_result (
      .clock         (clock),
      .reset         (reset),
      .view          (view),
      .view_in_id    (view_in_id),
      .view_out_id   (view_out_id),
      .min_out_time  (min_out_time_ff),
      .min_core_time (min_core_time_ff),
      .room          (room),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

`ifndef SYNTHESIS
   // eviction fields are zero unless an eviction was decided
   a_out_fields_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != ACT_OUT_IN) |-> (rsp_tdata[18:10] == '0))
      else $error("swap-out fields set without eviction");

   // no swap-in id when nothing is brought in
   a_in_field_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tdata[1:0] == ACT_NONE) || (rsp_tdata[1:0] == ACT_WAIT))
      |-> (rsp_tdata[9:2] == '0))
      else $error("swap-in id set without swap-in");

   // a held last entry must block the input while the result slot is full
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      view.valid && view.last && !room |-> !req_tready)
      else $error("input accepted while scan end is stalled");

   // nice shift and minimum core time register defaults after reset
   a_csr_reset: assert property (@(posedge clock)
      reset |=> (nice_shift_ff == NICE_SHIFT_RST) && (min_core_time_ff == MIN_CORE_TIME_RST))
      else $error("register default lost after reset");
`endif

endmodule
